// ===== rtl/core/barometric_compensation_top_defines.svh =====
// ----------------------------------------------------------------------------
// Barometric compensation assertion macros
// Shared concurrent assertion forms, clocked on i_clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef BAROMETRIC_COMPENSATION_TOP_DEFINES_SVH
`define BAROMETRIC_COMPENSATION_TOP_DEFINES_SVH

// same-cycle implication
`define BCOMP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BCOMP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bcomp_pkg.sv =====
// ----------------------------------------------------------------------------
// Barometric compensation package
// Payload types, register indexes and arithmetic constants.
// ----------------------------------------------------------------------------
package bcomp_pkg;

    typedef struct packed {
        logic [15:0] raw_temp;
        logic [18:0] raw_press;
    } t_bcomp_in;

    typedef struct packed {
        logic signed [15:0] temp_tenths;
        logic [17:0]        press_pa;
        logic               fault;
    } t_bcomp_out;

    localparam int BCOMP_NUM_W  = 32;
    localparam int BCOMP_DEN_W  = 20;
    localparam int BCOMP_SIDE_W = 40;

    localparam logic [2:0] BCOMP_REG_CAL_A = 3'd0;
    localparam logic [2:0] BCOMP_REG_CAL_B = 3'd1;
    localparam logic [2:0] BCOMP_REG_CAL_C = 3'd2;
    localparam logic [2:0] BCOMP_REG_CAL_D = 3'd3;
    localparam logic [2:0] BCOMP_REG_OSS   = 3'd4;

    localparam logic signed [27:0] BCOMP_B6_OFS   = 28'sd4000;
    localparam logic [15:0]        BCOMP_P_SCALE  = 16'd50000;
    localparam logic [31:0]        BCOMP_X3_BIAS  = 32'd32768;
    localparam logic [11:0]        BCOMP_C_SQ     = 12'd3038;
    localparam logic signed [14:0] BCOMP_C_LIN    = -15'sd7357;
    localparam logic signed [48:0] BCOMP_C_OFS    = 49'sd3791;
    localparam logic signed [49:0] BCOMP_P_MAX    = 50'sd262143;

endpackage

// ===== rtl/core/bcomp_div.sv =====
// ----------------------------------------------------------------------------
// Barometric compensation divider
// Unsigned restoring divider, one quotient bit per stage, with side payload.
// ----------------------------------------------------------------------------
module bcomp_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_vld,
    input  logic [bcomp_pkg::BCOMP_NUM_W-1:0]  i_num,
    input  logic [bcomp_pkg::BCOMP_DEN_W-1:0]  i_den,
    input  logic [bcomp_pkg::BCOMP_SIDE_W-1:0] i_side,
    output logic                             o_vld,
    output logic [bcomp_pkg::BCOMP_NUM_W-1:0]  o_quo,
    output logic [bcomp_pkg::BCOMP_SIDE_W-1:0] o_side
);

    localparam int NW = bcomp_pkg::BCOMP_NUM_W;
    localparam int DW = bcomp_pkg::BCOMP_DEN_W;
    localparam int SW = bcomp_pkg::BCOMP_SIDE_W;

    logic          r_vld  [NW];
    logic [DW-1:0] r_rem  [NW];
    logic [NW-1:0] r_quo  [NW];
    logic [DW-1:0] r_den  [NW];
    logic [SW-1:0] r_side [NW];

    logic [DW-1:0] n_rem  [NW];
    logic [NW-1:0] n_quo  [NW];

    always_comb begin
        logic [DW-1:0] s_rem;
        logic [NW-1:0] s_quo;
        logic [DW-1:0] s_den;
        logic [DW:0]   s_trial;
        logic          s_ge;
        for (int k = 0; k < NW; k++) begin
            if (k == 0) begin
                s_rem = '0;
                s_quo = i_num;
                s_den = i_den;
            end else begin
                s_rem = r_rem[k-1];
                s_quo = r_quo[k-1];
                s_den = r_den[k-1];
            end
            s_trial  = {s_rem, s_quo[NW-1]};
            s_ge     = s_trial >= {1'b0, s_den};
            n_rem[k] = s_ge ? DW'(s_trial - {1'b0, s_den}) : s_trial[DW-1:0];
            n_quo[k] = {s_quo[NW-2:0], s_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NW; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < NW; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
            for (int k = 1; k < NW; k++) begin
                r_den[k]  <= r_den[k-1];
                r_side[k] <= r_side[k-1];
            end
            for (int k = 0; k < NW; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
            end
        end
    end

    assign o_vld  = r_vld[NW-1];
    assign o_quo  = r_quo[NW-1];
    assign o_side = r_side[NW-1];

endmodule

// ===== rtl/core/barometric_compensation_top.sv =====
// ----------------------------------------------------------------------------
// Barometric compensation top level
// Integer temperature and pressure compensation from raw sensor words.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// in        request    i_in_valid / o_in_ready    i_in_data  (t_bcomp_in)
// out       result     o_out_valid / i_out_ready  o_out_data (t_bcomp_out)
// cfg       write      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One request per cycle sustained while the output is taken or empty; the pipeline is the
// two 32-stage restoring dividers plus 17 arithmetic and output stages.
// Reset clears the configuration registers and all valid bits.
// A full output register not taken stalls every stage at once; nothing moves.
// ----------------------------------------------------------------------------
`include "barometric_compensation_top_defines.svh"

module barometric_compensation_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  bcomp_pkg::t_bcomp_in  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output bcomp_pkg::t_bcomp_out o_out_data,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [47:0]           i_cfg_data
);

    localparam int NW = bcomp_pkg::BCOMP_NUM_W;
    localparam int DW = bcomp_pkg::BCOMP_DEN_W;
    localparam int SW = bcomp_pkg::BCOMP_SIDE_W;

    logic [47:0] r_cal_a, r_cal_b;
    logic [31:0] r_cal_c, r_cal_d;
    logic [1:0]  r_oss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
            r_cal_d <= '0;
            r_oss   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bcomp_pkg::BCOMP_REG_CAL_A: r_cal_a <= i_cfg_data;
                bcomp_pkg::BCOMP_REG_CAL_B: r_cal_b <= i_cfg_data;
                bcomp_pkg::BCOMP_REG_CAL_C: r_cal_c <= i_cfg_data[31:0];
                bcomp_pkg::BCOMP_REG_CAL_D: r_cal_d <= i_cfg_data[31:0];
                bcomp_pkg::BCOMP_REG_OSS:   r_oss   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [15:0]        ac4, ac5, ac6;

    assign ac1 = $signed(r_cal_a[47:32]);
    assign ac2 = $signed(r_cal_a[31:16]);
    assign ac3 = $signed(r_cal_a[15:0]);
    assign ac4 = r_cal_b[47:32];
    assign ac5 = r_cal_b[31:16];
    assign ac6 = r_cal_b[15:0];
    assign b1  = $signed(r_cal_c[31:16]);
    assign b2  = $signed(r_cal_c[15:0]);
    assign mc  = $signed(r_cal_d[31:16]);
    assign md  = $signed(r_cal_d[15:0]);

    logic en;
    logic r_out_vld;
    bcomp_pkg::t_bcomp_out r_out;

    assign en         = !r_out_vld || i_out_ready;
    assign o_in_ready = en;

    // stage 1..3: first temperature term and divider operands
    logic               r_s1_vld, r_s2_vld, r_s3_vld;
    logic signed [16:0] r_s1_d;
    logic [18:0]        r_s1_up, r_s2_up, r_s3_up;
    logic signed [33:0] r_s2_m;
    logic signed [18:0] r_s3_x1;
    logic [26:0]        r_s3_nmag;
    logic [19:0]        r_s3_dmag;
    logic               r_s3_neg, r_s3_flt;

    logic signed [18:0] s3_x1;
    logic signed [19:0] s3_den;
    logic signed [26:0] s3_num;

    always_comb begin
        s3_x1  = r_s2_m[33:15];
        s3_den = {s3_x1[18], s3_x1} + {{4{md[15]}}, md};
        s3_num = {mc, 11'b0};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_d    <= $signed({1'b0, i_in_data.raw_temp}) - $signed({1'b0, ac6});
            r_s1_up   <= i_in_data.raw_press;
            r_s2_m    <= r_s1_d * $signed({1'b0, ac5});
            r_s2_up   <= r_s1_up;
            r_s3_x1   <= s3_x1;
            r_s3_nmag <= s3_num[26] ? 27'(-s3_num) : s3_num;
            r_s3_dmag <= s3_den[19] ? 20'(-s3_den) : s3_den;
            r_s3_neg  <= s3_num[26] ^ s3_den[19];
            r_s3_flt  <= s3_den == 20'sd0;
            r_s3_up   <= r_s2_up;
        end
    end

    logic          d1_vld;
    logic [NW-1:0] d1_quo;
    logic [SW-1:0] d1_side;

    bcomp_div u_div_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_s3_vld),
        .i_num   (NW'(r_s3_nmag)),
        .i_den   (DW'(r_s3_dmag)),
        .i_side  ({r_s3_x1, r_s3_neg, r_s3_flt, r_s3_up}),
        .o_vld   (d1_vld),
        .o_quo   (d1_quo),
        .o_side  (d1_side)
    );

    // stage 4..12: temperature result and pressure divider operands
    logic               r_s4_vld, r_s5_vld, r_s6_vld, r_s7_vld, r_s8_vld;
    logic               r_s9_vld, r_s10_vld, r_s11_vld, r_s12_vld;
    logic signed [18:0] r_s4_x1;
    logic signed [27:0] r_s4_x2, r_s5_b5, r_s6_b6;
    logic               r_s4_flt, r_s5_flt, r_s6_flt, r_s7_flt, r_s8_flt;
    logic               r_s9_flt, r_s10_flt, r_s11_flt, r_s12_flt;
    logic [18:0]        r_s4_up, r_s5_up, r_s6_up, r_s7_up, r_s8_up, r_s9_up, r_s10_up;
    logic signed [15:0] r_s6_t, r_s7_t, r_s8_t, r_s9_t, r_s10_t, r_s11_t, r_s12_t;
    logic signed [55:0] r_s7_sqb;
    logic signed [43:0] r_s7_pa2, r_s7_pa3, r_s8_sq;
    logic signed [32:0] r_s8_x2a, r_s9_x2a;
    logic signed [30:0] r_s8_x1c, r_s9_x1c;
    logic signed [59:0] r_s9_mb1, r_s9_mb2;
    logic [31:0]        r_s10_b3, r_s10_arg, r_s11_dlt, r_s12_b7;
    logic [16:0]        r_s11_b4, r_s12_b4;

    logic signed [18:0] d1_x1;
    logic               d1_neg, d1_flt;
    logic [18:0]        d1_up;
    logic signed [27:0] s4_qm;
    logic signed [27:0] s6_tr;
    logic signed [23:0] s6_t24;
    logic signed [15:0] s6_t;
    logic [35:0]        s10_v, s10_w, s10_s;
    logic [47:0]        s11_prod;
    logic [15:0]        s12_mul;
    logic [47:0]        s12_prod;

    always_comb begin
        {d1_x1, d1_neg, d1_flt, d1_up} = d1_side;
        s4_qm  = $signed({1'b0, d1_quo[26:0]});
        s6_tr  = r_s5_b5 + 28'sd8;
        s6_t24 = s6_tr[27:4];
        if (s6_t24 > 24'sd32767) begin
            s6_t = 16'sh7FFF;
        end else if (s6_t24 < -24'sd32768) begin
            s6_t = -16'sh8000;
        end else begin
            s6_t = s6_t24[15:0];
        end
        s10_v = {{18{ac1[15]}}, ac1, 2'b00} + r_s9_mb2[46:11]
              + {{3{r_s9_x2a[32]}}, r_s9_x2a};
        s10_w = (s10_v << r_oss) + 36'd2;
        s10_s = {{5{r_s9_x1c[30]}}, r_s9_x1c} + r_s9_mb1[51:16] + 36'd2;
        s11_prod = ac4 * r_s10_arg;
        s12_mul  = bcomp_pkg::BCOMP_P_SCALE >> r_oss;
        s12_prod = r_s11_dlt * s12_mul;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_x1  <= d1_x1;
            r_s4_x2  <= d1_neg ? -s4_qm : s4_qm;
            r_s4_flt <= d1_flt;
            r_s4_up  <= d1_up;

            r_s5_b5  <= {{9{r_s4_x1[18]}}, r_s4_x1} + r_s4_x2;
            r_s5_flt <= r_s4_flt;
            r_s5_up  <= r_s4_up;

            r_s6_b6  <= r_s5_b5 - bcomp_pkg::BCOMP_B6_OFS;
            r_s6_t   <= s6_t;
            r_s6_flt <= r_s5_flt;
            r_s6_up  <= r_s5_up;

            r_s7_sqb <= r_s6_b6 * r_s6_b6;
            r_s7_pa2 <= ac2 * r_s6_b6;
            r_s7_pa3 <= ac3 * r_s6_b6;
            r_s7_t   <= r_s6_t;
            r_s7_flt <= r_s6_flt;
            r_s7_up  <= r_s6_up;

            r_s8_sq  <= r_s7_sqb[55:12];
            r_s8_x2a <= r_s7_pa2[43:11];
            r_s8_x1c <= r_s7_pa3[43:13];
            r_s8_t   <= r_s7_t;
            r_s8_flt <= r_s7_flt;
            r_s8_up  <= r_s7_up;

            r_s9_mb2 <= b2 * r_s8_sq;
            r_s9_mb1 <= b1 * r_s8_sq;
            r_s9_x2a <= r_s8_x2a;
            r_s9_x1c <= r_s8_x1c;
            r_s9_t   <= r_s8_t;
            r_s9_flt <= r_s8_flt;
            r_s9_up  <= r_s8_up;

            r_s10_b3  <= s10_w[33:2];
            r_s10_arg <= s10_s[33:2] + bcomp_pkg::BCOMP_X3_BIAS;
            r_s10_t   <= r_s9_t;
            r_s10_flt <= r_s9_flt;
            r_s10_up  <= r_s9_up;

            r_s11_b4  <= s11_prod[31:15];
            r_s11_dlt <= {13'b0, r_s10_up} - r_s10_b3;
            r_s11_t   <= r_s10_t;
            r_s11_flt <= r_s10_flt;

            r_s12_b7  <= s12_prod[31:0];
            r_s12_b4  <= r_s11_b4;
            r_s12_t   <= r_s11_t;
            r_s12_flt <= r_s11_flt || (r_s11_b4 == 17'd0);
        end
    end

    logic          d2_vld;
    logic [NW-1:0] d2_quo;
    logic [SW-1:0] d2_side;

    bcomp_div u_div_press (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_s12_vld),
        .i_num   (r_s12_b7[31] ? r_s12_b7 : {r_s12_b7[30:0], 1'b0}),
        .i_den   (DW'(r_s12_b4)),
        .i_side  ({r_s12_t, r_s12_flt, r_s12_b7[31], 22'b0}),
        .o_vld   (d2_vld),
        .o_quo   (d2_quo),
        .o_side  (d2_side)
    );

    // stage 14..17: pressure polynomial
    logic               r_s14_vld, r_s15_vld, r_s16_vld, r_s17_vld;
    logic [32:0]        r_s14_p, r_s15_p, r_s16_p;
    logic signed [15:0] r_s14_t, r_s15_t, r_s16_t, r_s17_t;
    logic               r_s14_flt, r_s15_flt, r_s16_flt, r_s17_flt;
    logic [49:0]        r_s15_sq;
    logic signed [47:0] r_s15_lin;
    logic [61:0]        r_s16_m3;
    logic signed [31:0] r_s16_x2;
    logic signed [49:0] r_s17_pr;

    logic signed [15:0] d2_t;
    logic               d2_flt, d2_big;
    logic [21:0]        d2_pad;
    logic [24:0]        s15_x1;
    logic signed [48:0] s17_s;

    always_comb begin
        {d2_t, d2_flt, d2_big, d2_pad} = d2_side;
        s15_x1 = r_s14_p[32:8];
        s17_s  = $signed({3'b0, r_s16_m3[61:16]}) + {{17{r_s16_x2[31]}}, r_s16_x2}
               + bcomp_pkg::BCOMP_C_OFS;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s14_p   <= d2_big ? {d2_quo, 1'b0} : {1'b0, d2_quo};
            r_s14_t   <= d2_t;
            r_s14_flt <= d2_flt;

            r_s15_sq  <= s15_x1 * s15_x1;
            r_s15_lin <= $signed({1'b0, r_s14_p}) * bcomp_pkg::BCOMP_C_LIN;
            r_s15_p   <= r_s14_p;
            r_s15_t   <= r_s14_t;
            r_s15_flt <= r_s14_flt;

            r_s16_m3  <= r_s15_sq * bcomp_pkg::BCOMP_C_SQ;
            r_s16_x2  <= r_s15_lin[47:16];
            r_s16_p   <= r_s15_p;
            r_s16_t   <= r_s15_t;
            r_s16_flt <= r_s15_flt;

            r_s17_pr  <= $signed({17'b0, r_s16_p}) + {{5{s17_s[48]}}, s17_s[48:4]};
            r_s17_t   <= r_s16_t;
            r_s17_flt <= r_s16_flt;

            if (r_s17_flt) begin
                r_out.temp_tenths <= '0;
                r_out.press_pa    <= '0;
                r_out.fault       <= 1'b1;
            end else begin
                r_out.temp_tenths <= r_s17_t;
                r_out.fault       <= 1'b0;
                if (r_s17_pr < 50'sd0) begin
                    r_out.press_pa <= '0;
                end else if (r_s17_pr > bcomp_pkg::BCOMP_P_MAX) begin
                    r_out.press_pa <= '1;
                end else begin
                    r_out.press_pa <= r_s17_pr[17:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_s6_vld  <= 1'b0;
            r_s7_vld  <= 1'b0;
            r_s8_vld  <= 1'b0;
            r_s9_vld  <= 1'b0;
            r_s10_vld <= 1'b0;
            r_s11_vld <= 1'b0;
            r_s12_vld <= 1'b0;
            r_s14_vld <= 1'b0;
            r_s15_vld <= 1'b0;
            r_s16_vld <= 1'b0;
            r_s17_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld  <= i_in_valid;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= d1_vld;
            r_s5_vld  <= r_s4_vld;
            r_s6_vld  <= r_s5_vld;
            r_s7_vld  <= r_s6_vld;
            r_s8_vld  <= r_s7_vld;
            r_s9_vld  <= r_s8_vld;
            r_s10_vld <= r_s9_vld;
            r_s11_vld <= r_s10_vld;
            r_s12_vld <= r_s11_vld;
            r_s14_vld <= d2_vld;
            r_s15_vld <= r_s14_vld;
            r_s16_vld <= r_s15_vld;
            r_s17_vld <= r_s16_vld;
            r_out_vld <= r_s17_vld;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    `BCOMP_ASSERT_IMP(a_fault_clears, o_out_valid && o_out_data.fault, o_out_data.temp_tenths == 16'sd0 && o_out_data.press_pa == 18'd0, "fault result carries values")
    `BCOMP_ASSERT_IMP(a_no_take_when_full, i_in_valid && o_in_ready, !o_out_valid || i_out_ready, "request taken while pipeline stalled")
    `BCOMP_ASSERT_NXT(a_entry_tracks, o_in_ready, r_s1_vld == $past(i_in_valid), "entry valid lost")

endmodule
